@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/wfhc_pkg.sv @@
package wfhc_pkg;

    // Sizing.
    localparam int SSID_BYTES = 32;
    localparam int LEN_BITS   = 12;
    localparam int POS_W      = LEN_BITS;
    localparam int FLEN_W     = LEN_BITS + 1;
    localparam int OFF_W      = LEN_BITS + 1;
    localparam int NCHAR_W    = $clog2(SSID_BYTES + 1);
    localparam int SSID_IDX_W = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Frame constants.
    localparam logic [FLEN_W-1:0] MIN_FRAME_LEN = FLEN_W'(28);
    localparam logic [FLEN_W-1:0] POS_LIMIT     = FLEN_W'(1) << LEN_BITS;
    localparam logic [47:0]       ADDR_ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [7:0]        PRINT_LO      = 8'h20;
    localparam logic [7:0]        PRINT_HI      = 8'h7E;
    localparam logic [7:0]        SUB_CHAR      = 8'h2E;
    localparam logic [OFF_W-1:0]  OFF_ASSOC     = OFF_W'(28);
    localparam logic [OFF_W-1:0]  OFF_REASSOC   = OFF_W'(34);
    localparam logic [OFF_W-1:0]  OFF_PROBE     = OFF_W'(24);
    localparam logic [OFF_W-1:0]  OFF_BEACON    = OFF_W'(36);

    // Frame classes.
    localparam logic [1:0] CLASS_MGMT = 2'd0;
    localparam logic [1:0] CLASS_CTRL = 2'd1;
    localparam logic [1:0] CLASS_DATA = 2'd2;
    localparam logic [1:0] CLASS_RSVD = 2'd3;

    // Network classes.
    localparam logic [1:0] NET_ASSOC  = 2'd0;
    localparam logic [1:0] NET_PROBE  = 2'd1;
    localparam logic [1:0] NET_BEACON = 2'd2;
    localparam logic [1:0] NET_OTHER  = 2'd3;

    // Result kinds.
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RSSI  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MGMT_ONLY = 1'd1;
    localparam logic signed [7:0]    MIN_RSSI_RESET = -8'sd100;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              last_byte;
        logic signed [7:0] rssi;
        logic [3:0]        channel;
        logic              rx_error;
        logic              pkt_other;
    } in_item_t;

    typedef struct packed {
        logic              item_kind;
        logic [1:0]        frame_class;
        logic [3:0]        subtype;
        logic [47:0]       source_addr;
        logic [47:0]       dest_addr;
        logic [47:0]       bssid_addr;
        logic [1:0]        net_class;
        logic [2:0]        update_flags;
        logic signed [7:0] rssi_out;
        logic [3:0]        channel_out;
        logic [7:0]        ssid_char;
        logic              last_of_run;
    } out_item_t;

    // One kept frame as it travels from the front to the back.
    typedef struct packed {
        logic [1:0]                  frame_class;
        logic [3:0]                  subtype;
        logic [47:0]                 source_addr;
        logic [47:0]                 dest_addr;
        logic [47:0]                 bssid_addr;
        logic [1:0]                  net_class;
        logic [2:0]                  update_flags;
        logic signed [7:0]           rssi;
        logic [3:0]                  channel;
        logic [NCHAR_W-1:0]          nchars;
        logic [SSID_BYTES-1:0][7:0]  ssid;
    } frame_entry_t;

    // Queue control driven by the back part.
    typedef struct packed {
        logic pop;
    } q_ctrl_t;

endpackage

@@ rtl/wlan_frame_header_classifier.sv @@
// Byte-serial 802.11 header classifier. The front takes one frame byte per cycle with no
// gaps of its own, tracks the frame control field, the three addresses and the SSID element,
// and in the cycle after the last byte filters the frame; a kept frame enters a two-frame
// queue. The back emits one result transaction per cycle from that queue while the receiver
// pops: a frame record, then up to 32 SSID characters. Input is held off (full) only when a
// finished frame waits and both queue slots hold frames still being drained. Configuration
// writes take effect at the next edge and should be made while no frame is in progress.
`include "assert_macros.svh"

module wlan_frame_header_classifier (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  wfhc_pkg::in_item_t     rx_item,
    input  logic                   wr_en,
    input  logic [wfhc_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]             wr_data,
    output logic                   empty,
    input  logic                   pop,
    output wfhc_pkg::out_item_t    result
);

    logic                   q_push;
    logic                   q_full;
    logic                   q_empty;
    wfhc_pkg::frame_entry_t q_entry;
    wfhc_pkg::frame_entry_t head;
    wfhc_pkg::q_ctrl_t      ctrl;

    // Parser and filter.
    wfhc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .rx_item  (rx_item),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // Frame queue between the two sides.
    wfhc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_push),
        .wr_entry (q_entry),
        .q_full   (q_full),
        .ctrl     (ctrl),
        .head     (head),
        .q_empty  (q_empty)
    );

    // Result serializer.
    wfhc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .ctrl    (ctrl),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // Checks.
    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, q_push, !q_full)
    `ASSERT_IMPLIES(a_last_frees, clk, rst_n, pop && !empty && result.last_of_run, ctrl.pop)
    `ASSERT_IMPLIES(a_record_no_char, clk, rst_n, !empty && result.item_kind == wfhc_pkg::KIND_RECORD, result.ssid_char == 8'h00)
    `ASSERT_NEXT(a_push_visible, clk, rst_n, q_push && q_empty, !empty)

endmodule

@@ rtl/wfhc_front.sv @@
module wfhc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  wfhc_pkg::in_item_t     rx_item,
    input  logic                   wr_en,
    input  logic [wfhc_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]             wr_data,
    input  logic                   q_full,
    output logic                   q_push,
    output wfhc_pkg::frame_entry_t q_entry
);

    typedef enum logic [1:0] {
        PH_AWAIT_ID,
        PH_AWAIT_LEN,
        PH_AWAIT_SSID_LEN,
        PH_IDLE
    } phase_t;

    // Parser state.
    logic [wfhc_pkg::POS_W-1:0]   byte_count_reg, byte_count_next;
    logic                         ovf_reg, ovf_next;
    logic [15:0]                  fcw_reg, fcw_next;
    logic [2:0][47:0]             addr_reg, addr_next;
    logic [wfhc_pkg::OFF_W-1:0]   next_off_reg, next_off_next;
    phase_t                       phase_reg, phase_next;
    logic [7:0]                   ssid_store_reg [wfhc_pkg::SSID_BYTES];
    logic                         store_we;
    logic [wfhc_pkg::SSID_IDX_W-1:0] store_idx;
    logic [7:0]                   store_data;
    logic [wfhc_pkg::NCHAR_W-1:0] ssid_len_reg, ssid_len_next;
    logic [wfhc_pkg::OFF_W-1:0]   elem_end_reg, elem_end_next;
    logic [wfhc_pkg::OFF_W-1:0]   first_pos_reg, first_pos_next;

    // Pending finish of the frame whose last byte was just taken.
    logic                         pend_reg, pend_next;
    logic signed [7:0]            pend_rssi_reg, pend_rssi_next;
    logic [3:0]                   pend_chan_reg, pend_chan_next;
    logic                         pend_err_reg, pend_err_next;
    logic                         pend_other_reg, pend_other_next;
    logic [wfhc_pkg::FLEN_W-1:0]  pend_flen_reg, pend_flen_next;

    // Configuration.
    logic signed [7:0]            min_rssi_reg;
    logic                         mgmt_only_reg;

    logic                         take;
    logic [7:0]                   b;
    logic [wfhc_pkg::OFF_W-1:0]   p_ext;
    logic [wfhc_pkg::OFF_W-1:0]   p_plus;
    logic [wfhc_pkg::OFF_W-1:0]   rel;
    logic [wfhc_pkg::OFF_W-1:0]   first_off;
    logic [1:0]                   b_kind;
    logic [3:0]                   b_sub;

    // Finish signals.
    logic [1:0]   f_kind;
    logic [3:0]   f_sub;
    logic         keep;
    logic         has_dst;
    logic         net;
    logic [47:0]  s_addr, d_addr, bs_addr;
    logic [1:0]   ncls;
    logic [wfhc_pkg::NCHAR_W-1:0] nchars;

    // A finished frame that cannot enter the queue holds off all input.
    assign full = pend_reg && q_full;
    assign take = push && !full;
    assign b    = rx_item.data_byte;
    assign p_ext  = wfhc_pkg::OFF_W'(byte_count_reg);
    assign p_plus = p_ext + wfhc_pkg::OFF_W'(1);
    assign rel    = p_ext - first_pos_reg;
    assign b_kind = b[3:2];
    assign b_sub  = b[7:4];

    // Start offset of the element walk for management subtypes.
    always_comb
    begin
        first_off = '0;
        if (b_kind == wfhc_pkg::CLASS_MGMT)
        begin
            case (b_sub)
                4'd0:    first_off = wfhc_pkg::OFF_ASSOC;
                4'd2:    first_off = wfhc_pkg::OFF_REASSOC;
                4'd4:    first_off = wfhc_pkg::OFF_PROBE;
                4'd5,
                4'd8:    first_off = wfhc_pkg::OFF_BEACON;
                default: first_off = '0;
            endcase
        end
    end

    // Per-byte parsing.
    always_comb
    begin
        byte_count_next = byte_count_reg;
        ovf_next        = ovf_reg;
        fcw_next        = fcw_reg;
        addr_next       = addr_reg;
        next_off_next   = next_off_reg;
        phase_next      = phase_reg;
        ssid_len_next   = ssid_len_reg;
        elem_end_next   = elem_end_reg;
        first_pos_next  = first_pos_reg;
        store_we        = 1'b0;
        store_idx       = rel[wfhc_pkg::SSID_IDX_W-1:0];
        store_data      = (b >= wfhc_pkg::PRINT_LO && b <= wfhc_pkg::PRINT_HI) ?
                          b : wfhc_pkg::SUB_CHAR;
        pend_next       = pend_reg && q_full;
        pend_rssi_next  = pend_rssi_reg;
        pend_chan_next  = pend_chan_reg;
        pend_err_next   = pend_err_reg;
        pend_other_next = pend_other_reg;
        pend_flen_next  = pend_flen_reg;

        if (take)
        begin
            if (!ovf_reg)
            begin
                if (byte_count_reg == '0)
                begin
                    fcw_next      = {8'h00, b};
                    addr_next     = '0;
                    ssid_len_next = '0;
                    elem_end_next = '0;
                    phase_next    = PH_IDLE;
                    if (first_off != '0)
                    begin
                        next_off_next = first_off;
                        phase_next    = PH_AWAIT_ID;
                    end
                end
                else
                begin
                    if (byte_count_reg == wfhc_pkg::POS_W'(1))
                    begin
                        fcw_next[15:8] = b;
                    end
                    for (int k = 0; k < 3; k++)
                    begin
                        for (int j = 0; j < 6; j++)
                        begin
                            if (byte_count_reg == wfhc_pkg::POS_W'(4 + 6 * k + j))
                            begin
                                addr_next[k][8*j +: 8] = b;
                            end
                        end
                    end
                    case (phase_reg)
                        PH_AWAIT_ID:
                        begin
                            if (p_ext == next_off_reg)
                            begin
                                phase_next = (b == 8'h00) ? PH_AWAIT_SSID_LEN : PH_AWAIT_LEN;
                            end
                        end
                        PH_AWAIT_LEN:
                        begin
                            next_off_next = p_plus + wfhc_pkg::OFF_W'(b);
                            phase_next    = PH_AWAIT_ID;
                        end
                        PH_AWAIT_SSID_LEN:
                        begin
                            first_pos_next = p_plus;
                            elem_end_next  = p_plus + wfhc_pkg::OFF_W'(b);
                            ssid_len_next  = ({1'b0, b} < 9'(wfhc_pkg::SSID_BYTES)) ?
                                             wfhc_pkg::NCHAR_W'(b) :
                                             wfhc_pkg::NCHAR_W'(wfhc_pkg::SSID_BYTES);
                            phase_next     = PH_IDLE;
                        end
                        default:
                        begin
                            if (ssid_len_reg != '0 && p_ext >= first_pos_reg &&
                                rel < wfhc_pkg::OFF_W'(ssid_len_reg))
                            begin
                                store_we = 1'b1;
                            end
                        end
                    endcase
                end
            end

            if (rx_item.last_byte)
            begin
                pend_next       = 1'b1;
                pend_rssi_next  = rx_item.rssi;
                pend_chan_next  = rx_item.channel;
                pend_err_next   = rx_item.rx_error;
                pend_other_next = rx_item.pkt_other;
                pend_flen_next  = ovf_reg ? wfhc_pkg::POS_LIMIT :
                                  wfhc_pkg::FLEN_W'(byte_count_reg) + wfhc_pkg::FLEN_W'(1);
                byte_count_next = '0;
                ovf_next        = 1'b0;
                phase_next      = PH_IDLE;
            end
            else if (!ovf_reg)
            begin
                if (byte_count_reg == '1)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    byte_count_next = byte_count_reg + wfhc_pkg::POS_W'(1);
                end
            end
        end
    end

    // Frame filter and address selection on the finished frame.
    assign f_kind = fcw_reg[3:2];
    assign f_sub  = fcw_reg[7:4];

    always_comb
    begin
        keep    = 1'b1;
        has_dst = 1'b1;
        s_addr  = addr_reg[1];
        d_addr  = addr_reg[0];
        bs_addr = addr_reg[2];
        ncls    = wfhc_pkg::NET_OTHER;
        nchars  = '0;

        if (pend_other_reg || pend_err_reg ||
            pend_flen_reg < wfhc_pkg::MIN_FRAME_LEN ||
            pend_rssi_reg < min_rssi_reg ||
            f_kind == wfhc_pkg::CLASS_RSVD ||
            (f_kind != wfhc_pkg::CLASS_MGMT && mgmt_only_reg))
        begin
            keep = 1'b0;
        end

        case (f_kind)
            wfhc_pkg::CLASS_MGMT:
            begin
                case (f_sub)
                    4'd0,
                    4'd2:    ncls = wfhc_pkg::NET_ASSOC;
                    4'd4:    ncls = wfhc_pkg::NET_PROBE;
                    4'd5,
                    4'd8:    ncls = wfhc_pkg::NET_BEACON;
                    default: ncls = wfhc_pkg::NET_OTHER;
                endcase
                if (ssid_len_reg != '0 &&
                    wfhc_pkg::FLEN_W'(elem_end_reg) <= pend_flen_reg)
                begin
                    nchars = ssid_len_reg;
                end
            end
            wfhc_pkg::CLASS_CTRL:
            begin
                if (f_sub inside {[4'd8:4'd11], 4'd13})
                begin
                    s_addr = addr_reg[1];
                end
                else if (f_sub inside {4'd14, 4'd15})
                begin
                    s_addr  = addr_reg[0];
                    bs_addr = addr_reg[1];
                    d_addr  = '0;
                    has_dst = 1'b0;
                end
                else
                begin
                    keep = 1'b0;
                end
            end
            wfhc_pkg::CLASS_DATA:
            begin
                if (!fcw_reg[9])
                begin
                    s_addr = addr_reg[1];
                end
                else if (!fcw_reg[8])
                begin
                    bs_addr = addr_reg[1];
                    s_addr  = addr_reg[2];
                end
                else
                begin
                    d_addr  = addr_reg[2];
                    bs_addr = addr_reg[0];
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase

        net = (bs_addr != wfhc_pkg::ADDR_ALL_ONES) ||
              (f_kind == wfhc_pkg::CLASS_MGMT && nchars != '0);
    end

    // Queue entry for the finished frame.
    always_comb
    begin
        q_entry.frame_class   = f_kind;
        q_entry.subtype       = f_sub;
        q_entry.source_addr   = s_addr;
        q_entry.dest_addr     = d_addr;
        q_entry.bssid_addr    = bs_addr;
        q_entry.net_class     = ncls;
        q_entry.update_flags  = {bs_addr != wfhc_pkg::ADDR_ALL_ONES && bs_addr != '0,
                                 has_dst && d_addr != wfhc_pkg::ADDR_ALL_ONES,
                                 net};
        q_entry.rssi          = pend_rssi_reg;
        q_entry.channel       = pend_chan_reg;
        q_entry.nchars        = nchars;
        for (int i = 0; i < wfhc_pkg::SSID_BYTES; i++)
        begin
            q_entry.ssid[i] = ssid_store_reg[i];
        end
    end

    assign q_push = pend_reg && !q_full && keep;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            ovf_reg        <= 1'b0;
            fcw_reg        <= '0;
            addr_reg       <= '0;
            next_off_reg   <= '0;
            phase_reg      <= PH_IDLE;
            ssid_len_reg   <= '0;
            elem_end_reg   <= '0;
            first_pos_reg  <= '0;
            pend_reg       <= 1'b0;
            min_rssi_reg   <= wfhc_pkg::MIN_RSSI_RESET;
            mgmt_only_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            ovf_reg        <= ovf_next;
            fcw_reg        <= fcw_next;
            addr_reg       <= addr_next;
            next_off_reg   <= next_off_next;
            phase_reg      <= phase_next;
            ssid_len_reg   <= ssid_len_next;
            elem_end_reg   <= elem_end_next;
            first_pos_reg  <= first_pos_next;
            pend_reg       <= pend_next;
            if (wr_en)
            begin
                case (wr_index)
                    wfhc_pkg::REG_MIN_RSSI:  min_rssi_reg  <= wr_data;
                    wfhc_pkg::REG_MGMT_ONLY: mgmt_only_reg <= wr_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers of the pending frame and the SSID store.
    always_ff @(posedge clk)
    begin
        pend_rssi_reg  <= pend_rssi_next;
        pend_chan_reg  <= pend_chan_next;
        pend_err_reg   <= pend_err_next;
        pend_other_reg <= pend_other_next;
        pend_flen_reg  <= pend_flen_next;
        if (store_we)
        begin
            ssid_store_reg[store_idx] <= store_data;
        end
    end

endmodule

@@ rtl/wfhc_queue.sv @@
module wfhc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr,
    input  wfhc_pkg::frame_entry_t wr_entry,
    output logic                   q_full,
    input  wfhc_pkg::q_ctrl_t      ctrl,
    output wfhc_pkg::frame_entry_t head,
    output logic                   q_empty
);

    wfhc_pkg::frame_entry_t        mem_reg [wfhc_pkg::QDEPTH];
    logic [wfhc_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [wfhc_pkg::QCNT_W-1:0]   count_reg;
    logic                          rd;

    assign q_full  = count_reg == wfhc_pkg::QCNT_W'(wfhc_pkg::QDEPTH);
    assign q_empty = count_reg == '0;
    assign rd      = ctrl.pop && !q_empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == wfhc_pkg::QPTR_W'(wfhc_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + wfhc_pkg::QPTR_W'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == wfhc_pkg::QPTR_W'(wfhc_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + wfhc_pkg::QPTR_W'(1);
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + wfhc_pkg::QCNT_W'(1);
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - wfhc_pkg::QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ rtl/wfhc_back.sv @@
module wfhc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wfhc_pkg::frame_entry_t head,
    input  logic                   q_empty,
    output wfhc_pkg::q_ctrl_t      ctrl,
    output logic                   empty,
    input  logic                   pop,
    output wfhc_pkg::out_item_t    result
);

    logic [wfhc_pkg::NCHAR_W-1:0] idx_reg;
    logic [wfhc_pkg::NCHAR_W-1:0] idx_m1;
    logic                         taken;

    assign empty  = q_empty;
    assign taken  = pop && !q_empty;
    assign idx_m1 = idx_reg - wfhc_pkg::NCHAR_W'(1);

    // Record first, then one character per transaction.
    always_comb
    begin
        result = '0;
        if (idx_reg == '0)
        begin
            result.item_kind     = wfhc_pkg::KIND_RECORD;
            result.frame_class   = head.frame_class;
            result.subtype       = head.subtype;
            result.source_addr   = head.source_addr;
            result.dest_addr     = head.dest_addr;
            result.bssid_addr    = head.bssid_addr;
            result.net_class     = head.net_class;
            result.update_flags  = head.update_flags;
            result.rssi_out      = head.rssi;
            result.channel_out   = head.channel;
            result.last_of_run   = head.nchars == '0;
        end
        else
        begin
            result.item_kind   = wfhc_pkg::KIND_CHAR;
            result.ssid_char   = head.ssid[idx_m1[wfhc_pkg::SSID_IDX_W-1:0]];
            result.last_of_run = idx_reg == head.nchars;
        end
    end

    assign ctrl.pop = taken && result.last_of_run;

    // Position within the current frame's run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (taken)
        begin
            idx_reg <= result.last_of_run ? '0 : idx_reg + wfhc_pkg::NCHAR_W'(1);
        end
    end

endmodule

@@ test/wlan_frame_header_classifier_test.sv @@
module wlan_frame_header_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Management subtypes that start an element walk, the CF-End control subtypes and bench constants.
    localparam logic [3:0] SUB_ASSOC_REQ   = 4'd0;
    localparam logic [3:0] SUB_REASSOC_REQ = 4'd2;
    localparam logic [3:0] SUB_PROBE_REQ   = 4'd4;
    localparam logic [3:0] SUB_PROBE_RESP  = 4'd5;
    localparam logic [3:0] SUB_BEACON      = 4'd8;
    localparam logic [3:0] SUB_CF_END      = 4'd14;
    localparam logic [3:0] SUB_CF_END_ACK  = 4'd15;
    localparam logic [7:0] ELEM_SSID       = 8'd0;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 12;

    typedef enum logic [1:0] {EL_ID, EL_SKIP_LEN, EL_SSID_LEN, EL_IDLE} elem_phase_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    wfhc_pkg::in_item_t rx_item;
    logic wr_en;
    logic [wfhc_pkg::CFG_IDX_W-1:0] wr_index;
    logic [7:0] wr_data;
    logic empty;
    logic pop;
    wfhc_pkg::out_item_t result;

    wlan_frame_header_classifier dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_item(rx_item),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    // Predictor state for the classifier.
    int unsigned frame_pos;
    bit pos_overflow;
    logic [15:0] fc_word;
    logic [47:0] addr_field [3];
    int unsigned elem_offset;
    elem_phase_t elem_phase;
    logic [7:0] ssid_bytes [wfhc_pkg::SSID_BYTES];
    int unsigned ssid_len;
    int unsigned ssid_end;
    int unsigned ssid_first;
    logic signed [7:0] cfg_min_rssi;
    bit cfg_mgmt_only;

    wfhc_pkg::out_item_t expected_results [$];
    logic [7:0] frame_bytes [$];
    int fail_count;
    int mismatch_count;
    int bytes_sent;
    int hold_request;
    bit steady_push;
    bit steady_pop;
    int unsigned cycle_count;

    // Clock.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[wlan_frame_header_classifier] ERROR");
            $finish;
        end
    end

    // Consume one received byte in the predictor.
    task automatic capture_byte(input int unsigned p, input logic [7:0] b);
        logic [3:0] sub;
        logic [1:0] kind;
        int unsigned first;
        int unsigned k;
        sub = b[7:4];
        kind = b[3:2];
        if (p == 0)
        begin
            first = 0;
            fc_word = {8'h00, b};
            for (int i = 0; i < 3; i++)
                addr_field[i] = '0;
            ssid_len = 0;
            ssid_end = 0;
            elem_phase = EL_IDLE;
            if (kind == wfhc_pkg::CLASS_MGMT)
            begin
                if (sub == SUB_ASSOC_REQ)
                    first = wfhc_pkg::OFF_ASSOC;
                else if (sub == SUB_REASSOC_REQ)
                    first = wfhc_pkg::OFF_REASSOC;
                else if (sub == SUB_PROBE_REQ)
                    first = wfhc_pkg::OFF_PROBE;
                else if (sub == SUB_PROBE_RESP || sub == SUB_BEACON)
                    first = wfhc_pkg::OFF_BEACON;
            end
            if (first != 0)
            begin
                elem_offset = first;
                elem_phase = EL_ID;
            end
        end
        else if (p == 1)
        begin
            fc_word[15:8] = b;
        end
        if (p >= 4 && p < 22)
        begin
            k = (p - 4) / 6;
            addr_field[k][((p - 4) % 6) * 8 +: 8] = b;
        end
        case (elem_phase)
            EL_ID:
            begin
                if (p == elem_offset)
                    elem_phase = (b == ELEM_SSID) ? EL_SSID_LEN : EL_SKIP_LEN;
            end
            EL_SKIP_LEN:
            begin
                elem_offset = p + 1 + b;
                elem_phase = EL_ID;
            end
            EL_SSID_LEN:
            begin
                ssid_first = p + 1;
                ssid_end = p + 1 + b;
                ssid_len = (b < wfhc_pkg::SSID_BYTES) ? b : wfhc_pkg::SSID_BYTES;
                elem_phase = EL_IDLE;
            end
            default:
            begin
                if (ssid_len != 0 && p >= ssid_first && p - ssid_first < ssid_len)
                    ssid_bytes[p - ssid_first] =
                        (b >= wfhc_pkg::PRINT_LO && b <= wfhc_pkg::PRINT_HI) ?
                        b : wfhc_pkg::SUB_CHAR;
            end
        endcase
    endtask

    // Filter a finished frame and queue its record and SSID characters.
    task automatic classify_frame(input wfhc_pkg::in_item_t it);
        int unsigned flen;
        logic [1:0] kind;
        logic [3:0] sub;
        logic [47:0] src;
        logic [47:0] dst;
        logic [47:0] bss;
        bit has_dst;
        bit net;
        int unsigned nchars;
        wfhc_pkg::out_item_t rec;
        flen = pos_overflow ? wfhc_pkg::POS_LIMIT : frame_pos + 1;
        kind = fc_word[3:2];
        sub = fc_word[7:4];
        has_dst = 1'b1;
        nchars = 0;
        dst = '0;
        rec = '0;
        rec.net_class = wfhc_pkg::NET_OTHER;
        if (it.pkt_other || flen < wfhc_pkg::MIN_FRAME_LEN || it.rx_error)
            return;
        if (it.rssi < cfg_min_rssi || kind == wfhc_pkg::CLASS_RSVD)
            return;
        if (kind != wfhc_pkg::CLASS_MGMT && cfg_mgmt_only)
            return;
        if (kind == wfhc_pkg::CLASS_MGMT)
        begin
            src = addr_field[1];
            dst = addr_field[0];
            bss = addr_field[2];
            if (sub == SUB_ASSOC_REQ || sub == SUB_REASSOC_REQ)
                rec.net_class = wfhc_pkg::NET_ASSOC;
            else if (sub == SUB_PROBE_REQ)
                rec.net_class = wfhc_pkg::NET_PROBE;
            else if (sub == SUB_PROBE_RESP || sub == SUB_BEACON)
                rec.net_class = wfhc_pkg::NET_BEACON;
            if (ssid_len > 0 && ssid_end <= flen)
                nchars = ssid_len;
            net = nchars > 0 || bss != wfhc_pkg::ADDR_ALL_ONES;
        end
        else if (kind == wfhc_pkg::CLASS_CTRL)
        begin
            if ((sub >= 8 && sub <= 11) || sub == 13)
            begin
                dst = addr_field[0];
                src = addr_field[1];
                bss = addr_field[2];
            end
            else if (sub == SUB_CF_END || sub == SUB_CF_END_ACK)
            begin
                src = addr_field[0];
                bss = addr_field[1];
                has_dst = 1'b0;
            end
            else
            begin
                return;
            end
            net = bss != wfhc_pkg::ADDR_ALL_ONES;
        end
        else
        begin
            // Address roles follow the distribution system bits.
            if (!fc_word[9])
            begin
                src = addr_field[1];
                dst = addr_field[0];
                bss = addr_field[2];
            end
            else if (!fc_word[8])
            begin
                dst = addr_field[0];
                bss = addr_field[1];
                src = addr_field[2];
            end
            else
            begin
                dst = addr_field[2];
                src = addr_field[1];
                bss = addr_field[0];
            end
            net = bss != wfhc_pkg::ADDR_ALL_ONES;
        end
        rec.item_kind = wfhc_pkg::KIND_RECORD;
        rec.frame_class = kind;
        rec.subtype = sub;
        rec.source_addr = src;
        rec.dest_addr = dst;
        rec.bssid_addr = bss;
        rec.update_flags[0] = net;
        rec.update_flags[1] = has_dst && dst != wfhc_pkg::ADDR_ALL_ONES;
        rec.update_flags[2] = bss != wfhc_pkg::ADDR_ALL_ONES && bss != '0;
        rec.rssi_out = it.rssi;
        rec.channel_out = it.channel;
        rec.last_of_run = (nchars == 0);
        expected_results.push_back(rec);
        for (int i = 0; i < nchars; i++)
        begin
            rec = '0;
            rec.item_kind = wfhc_pkg::KIND_CHAR;
            rec.ssid_char = ssid_bytes[i];
            rec.last_of_run = (i + 1 == nchars);
            expected_results.push_back(rec);
        end
    endtask

    // Advance the predictor by one accepted byte.
    task automatic predict_byte(input wfhc_pkg::in_item_t it);
        if (!pos_overflow)
            capture_byte(frame_pos, it.data_byte);
        if (it.last_byte)
        begin
            classify_frame(it);
            frame_pos = 0;
            pos_overflow = 1'b0;
            elem_phase = EL_IDLE;
        end
        else if (!pos_overflow)
        begin
            if (frame_pos >= wfhc_pkg::POS_LIMIT - 1)
                pos_overflow = 1'b1;
            else
                frame_pos++;
        end
    endtask

    // Compare every accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        wfhc_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: %h", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.item_kind !== want.item_kind
                    || result.frame_class !== want.frame_class
                    || result.subtype !== want.subtype
                    || result.source_addr !== want.source_addr
                    || result.dest_addr !== want.dest_addr
                    || result.bssid_addr !== want.bssid_addr
                    || result.net_class !== want.net_class
                    || result.update_flags !== want.update_flags
                    || result.rssi_out !== want.rssi_out
                    || result.channel_out !== want.channel_out
                    || result.ssid_char !== want.ssid_char
                    || result.last_of_run !== want.last_of_run)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %h actual %h", want, result);
                end
            end
        end
    end

    // Receiver side: random pops, with a long hold when one is requested.
    initial
    begin
        int gap;
        gap = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                pop = 1'b0;
                hold_request--;
            end
            else if (gap > 0)
            begin
                pop = 1'b0;
                gap--;
            end
            else
            begin
                pop = 1'b1;
                if (!steady_pop && $urandom_range(0, 5) == 0)
                    gap = ($urandom_range(0, 6) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(1, 3);
            end
        end
    end

    // Send one byte and wait until the block accepts the transaction.
    task automatic send_byte(input wfhc_pkg::in_item_t it);
        int gap;
        gap = 0;
        if (!steady_push && $urandom_range(0, 7) == 0)
            gap = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push = 1'b1;
        rx_item = it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_byte(it);
        bytes_sent++;
    endtask

    // Send the bytes in frame_bytes; per-frame fields travel with the last byte.
    task automatic send_frame(input logic signed [7:0] rssi, input logic [3:0] channel,
                              input bit rx_error, input bit pkt_other);
        wfhc_pkg::in_item_t it;
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            it.data_byte = frame_bytes[i];
            it.last_byte = (i == frame_bytes.size() - 1);
            it.rssi = 8'($urandom);
            it.channel = 4'($urandom);
            it.rx_error = 1'($urandom);
            it.pkt_other = 1'($urandom);
            if (it.last_byte)
            begin
                it.rssi = rssi;
                it.channel = channel;
                it.rx_error = rx_error;
                it.pkt_other = pkt_other;
            end
            send_byte(it);
        end
    endtask

    function automatic logic [7:0] random_ssid_char();
        return ($urandom_range(0, 9) < 7) ?
               8'($urandom_range(wfhc_pkg::PRINT_LO, wfhc_pkg::PRINT_HI)) : 8'($urandom);
    endfunction

    // Build a frame: header, fixed fields up to the element start, optional
    // other element and an optional SSID element, padding, then cut bytes off the end.
    task automatic build_frame(input logic [1:0] kind, input logic [3:0] sub,
                               input int ssid_size, input int min_len, input int cut);
        int start;
        int elen;
        int mode;
        logic [47:0] a;
        frame_bytes.delete();
        frame_bytes.push_back({sub, kind, 2'($urandom)});
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        for (int k = 0; k < 3; k++)
        begin
            mode = $urandom_range(0, 7);
            a = 48'({$urandom, $urandom});
            if (mode == 6)
                a = wfhc_pkg::ADDR_ALL_ONES;
            else if (mode == 7)
                a = '0;
            for (int j = 0; j < 6; j++)
                frame_bytes.push_back(a[j * 8 +: 8]);
        end
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        start = 24;
        if (sub == SUB_ASSOC_REQ)
            start = wfhc_pkg::OFF_ASSOC;
        else if (sub == SUB_REASSOC_REQ)
            start = wfhc_pkg::OFF_REASSOC;
        else if (sub == SUB_PROBE_RESP || sub == SUB_BEACON)
            start = wfhc_pkg::OFF_BEACON;
        while (frame_bytes.size() < start)
            frame_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 3) == 0)
        begin
            elen = $urandom_range(0, 6);
            frame_bytes.push_back(8'($urandom_range(1, 255)));
            frame_bytes.push_back(8'(elen));
            repeat (elen) frame_bytes.push_back(8'($urandom));
        end
        if (ssid_size >= 0)
        begin
            frame_bytes.push_back(ELEM_SSID);
            frame_bytes.push_back(8'(ssid_size));
            repeat (ssid_size) frame_bytes.push_back(random_ssid_char());
        end
        while (frame_bytes.size() < min_len)
            frame_bytes.push_back(8'($urandom));
        repeat (cut)
            if (frame_bytes.size() > 1)
                void'(frame_bytes.pop_back());
    endtask

    // Let the block drain, then write one register.
    task automatic write_register(input logic [wfhc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [7:0] value);
        @(negedge clk);
        push = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = value;
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == wfhc_pkg::REG_MIN_RSSI)
            cfg_min_rssi = value;
        else if (idx == wfhc_pkg::REG_MGMT_ONLY)
            cfg_mgmt_only = value[0];
    endtask

    // Every frame class, subtype handling and drop reason but the management-only filter.
    task automatic test_directed();
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 8, 40, 0);
        send_frame(8'sd127, 4'd15, 0, 0);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_PROBE_REQ, 5, 28, 0);
        send_frame(-8'sd100, 4'd0, 0, 0);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_ASSOC_REQ, 3, 28, 0);
        send_frame(-8'sd20, 4'd6, 0, 0);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_REASSOC_REQ, 12, 28, 0);
        send_frame(-8'sd40, 4'd11, 0, 0);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_PROBE_RESP, 40, 28, 0);
        send_frame(-8'sd50, 4'd1, 0, 0);
        // An empty SSID ends the walk with no characters.
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 0, 50, 0);
        send_frame(-8'sd30, 4'd3, 0, 0);
        // An SSID element running past the end of the frame is not reported.
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 10, 0, 3);
        send_frame(-8'sd30, 4'd3, 0, 0);
        build_frame(wfhc_pkg::CLASS_MGMT, 4'd12, 6, 30, 0);
        send_frame(-8'sd30, 4'd2, 0, 0);
        // Drop reasons: short frame, receive error, other packet, weak signal, reserved type.
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, -1, 0, 20);
        send_frame(-8'sd30, 4'd2, 0, 0);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 4, 28, 0);
        send_frame(-8'sd30, 4'd2, 1, 0);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 4, 28, 0);
        send_frame(-8'sd30, 4'd2, 0, 1);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 4, 28, 0);
        send_frame(-8'sd101, 4'd2, 0, 0);
        build_frame(wfhc_pkg::CLASS_RSVD, 4'd0, -1, 30, 0);
        send_frame(-8'sd30, 4'd2, 0, 0);
        // Control subtypes, including the CF-End pair and dropped ones.
        for (int s = 7; s <= 15; s++)
        begin
            build_frame(wfhc_pkg::CLASS_CTRL, 4'(s), -1, 28, 0);
            send_frame(-8'sd128 + 8'sd28, 4'(s), 0, 0);
        end
        // Data frames whose distribution bit pairs come from the random second byte.
        repeat (4)
        begin
            build_frame(wfhc_pkg::CLASS_DATA, 4'($urandom), -1, 32, 0);
            send_frame(-8'sd10, 4'd9, 0, 0);
        end
    endtask

    // A frame longer than the position counter covers.
    task automatic test_overlong_frame();
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 20, (1 << wfhc_pkg::LEN_BITS) + 5, 0);
        send_frame(8'sd0, 4'd7, 0, 0);
    endtask

    // Hold the receiver off while frames keep arriving, so the input stalls.
    task automatic test_backpressure();
        steady_push = 1'b1;
        hold_request = 400;
        repeat (5)
        begin
            build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 32, 28, 0);
            send_frame(8'sd5, 4'd4, 0, 0);
        end
        steady_push = 1'b0;
    endtask

    // Register extremes: threshold at both ends and management-only filtering.
    task automatic test_register_settings();
        write_register(wfhc_pkg::REG_MGMT_ONLY, 8'd1);
        build_frame(wfhc_pkg::CLASS_CTRL, 4'd11, -1, 28, 0);
        send_frame(8'sd0, 4'd1, 0, 0);
        build_frame(wfhc_pkg::CLASS_DATA, 4'd0, -1, 28, 0);
        send_frame(8'sd0, 4'd1, 0, 0);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_PROBE_REQ, 7, 28, 0);
        send_frame(8'sd0, 4'd1, 0, 0);
        write_register(wfhc_pkg::REG_MIN_RSSI, 8'h7F);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 3, 28, 0);
        send_frame(8'sd126, 4'd1, 0, 0);
        build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, 3, 28, 0);
        send_frame(8'sd127, 4'd1, 0, 0);
        write_register(wfhc_pkg::REG_MIN_RSSI, 8'h80);
        write_register(wfhc_pkg::REG_MGMT_ONLY, 8'd0);
        build_frame(wfhc_pkg::CLASS_DATA, 4'd8, -1, 28, 0);
        send_frame(-8'sd128, 4'd1, 0, 0);
    endtask

    // Random frames, mostly well formed, some noise, under several settings.
    task automatic test_random_frames();
        int start_bytes;
        int pick;
        int phase_idx;
        start_bytes = bytes_sent;
        phase_idx = 0;
        while (bytes_sent - start_bytes < 210)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                phase_idx++;
                write_register(wfhc_pkg::REG_MIN_RSSI,
                               (phase_idx % 3 == 0) ? 8'h9C : 8'($urandom));
                write_register(wfhc_pkg::REG_MGMT_ONLY, 8'($urandom_range(0, 3) == 0));
            end
            steady_push = ($urandom_range(0, 3) == 0);
            steady_pop = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                case ($urandom_range(0, 4))
                    0: build_frame(wfhc_pkg::CLASS_MGMT, SUB_ASSOC_REQ, $urandom_range(0, 36),
                                   $urandom_range(28, 44), ($urandom_range(0, 7) == 0) * 4);
                    1: build_frame(wfhc_pkg::CLASS_MGMT, SUB_REASSOC_REQ, $urandom_range(0, 36),
                                   $urandom_range(28, 44), ($urandom_range(0, 7) == 0) * 4);
                    2: build_frame(wfhc_pkg::CLASS_MGMT, SUB_PROBE_REQ, $urandom_range(0, 36),
                                   $urandom_range(28, 44), ($urandom_range(0, 7) == 0) * 4);
                    3: build_frame(wfhc_pkg::CLASS_MGMT, SUB_PROBE_RESP, $urandom_range(0, 36),
                                   $urandom_range(28, 44), ($urandom_range(0, 7) == 0) * 4);
                    default: build_frame(wfhc_pkg::CLASS_MGMT, SUB_BEACON, $urandom_range(0, 36),
                                   $urandom_range(28, 44), ($urandom_range(0, 7) == 0) * 4);
                endcase
            end
            else if (pick < 8)
            begin
                build_frame(2'($urandom_range(1, 3)), 4'($urandom), -1,
                            $urandom_range(26, 40), 0);
            end
            else
            begin
                frame_bytes.delete();
                repeat ($urandom_range(2, 50)) frame_bytes.push_back(8'($urandom));
            end
            send_frame(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)),
                       4'($urandom), ($urandom_range(0, 15) == 0),
                       ($urandom_range(0, 15) == 0));
        end
        steady_push = 1'b0;
        steady_pop = 1'b0;
    endtask

    initial
    begin
        cycle_count = 0;
        rst_n = 1'b0;
        push = 1'b0;
        rx_item = '0;
        wr_en = 1'b0;
        wr_index = wfhc_pkg::REG_MIN_RSSI;
        wr_data = '0;
        hold_request = 0;
        steady_push = 1'b0;
        steady_pop = 1'b0;
        fail_count = 0;
        mismatch_count = 0;
        bytes_sent = 0;
        frame_pos = 0;
        pos_overflow = 1'b0;
        fc_word = '0;
        for (int i = 0; i < 3; i++)
            addr_field[i] = '0;
        elem_offset = 0;
        elem_phase = EL_IDLE;
        ssid_len = 0;
        ssid_end = 0;
        ssid_first = 0;
        cfg_min_rssi = wfhc_pkg::MIN_RSSI_RESET;
        cfg_mgmt_only = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_overlong_frame();
        test_backpressure();
        test_register_settings();
        test_random_frames();

        @(negedge clk);
        push = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        fail_count += expected_results.size();
        if (fail_count == 0)
            $display("[wlan_frame_header_classifier] OK");
        else
            $display("[wlan_frame_header_classifier] ERROR");
        $finish;
    end

endmodule
